[src/bounded_sorted_list_engine_unit_assert.svh]
`ifndef BOUNDED_SORTED_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_SORTED_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BSLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/bsle_pkg.sv]
package bsle_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int OCC_W           = 5;

  typedef enum logic [1:0] {
    KIND_FRONT  = 2'd0,
    KIND_BACK   = 2'd1,
    KIND_SORTED = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [FIELD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] item_value;
    logic [OCC_W-1:0]          occupancy;
    status_t                   status;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic  ins;
    logic  rot;
    kind_t kind;
  } cell_ctrl_t;

endpackage

[src/bsle_cell.sv]
module bsle_cell #(
  parameter int VALUE_WIDTH = bsle_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsle_pkg::cell_ctrl_t   ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic [VALUE_WIDTH-1:0] head_value,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic                   left_valid,
  input  logic [VALUE_WIDTH-1:0] right_value,
  input  logic                   right_valid,
  input  logic                   hit_in,
  output logic                   hit_out,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   valid
);
  import bsle_pkg::*;

  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   valid_r, valid_nxt;
  logic                   mark;

  always_comb begin
    case (ctrl.kind)
      KIND_FRONT:  mark = 1'b1;
      KIND_BACK:   mark = !valid_r;
      KIND_SORTED: mark = !valid_r || ($signed(value_r) >= $signed(new_value));
      default:     mark = 1'b0;
    endcase
  end

  assign hit_out = hit_in | mark;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.ins) begin
      if (hit_in) begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end else if (mark) begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.rot && valid_r) begin
      value_nxt = right_valid ? right_value : head_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

[src/bsle_chain.sv]
module bsle_chain #(
  parameter int CAPACITY    = bsle_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bsle_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsle_pkg::cell_ctrl_t   ctrl,
  input  logic [VALUE_WIDTH-1:0] new_value,
  output logic [VALUE_WIDTH-1:0] head_value
);
  import bsle_pkg::*;

  logic [VALUE_WIDTH-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]    valids;
  logic [CAPACITY:0]      hits;

  assign hits[0]    = 1'b0;
  assign head_value = vals[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_value;
    logic                   left_valid;
    logic [VALUE_WIDTH-1:0] right_value;
    logic                   right_valid;

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_valid = 1'b0;
    end else begin : g_mid_left
      assign left_value = vals[i-1];
      assign left_valid = valids[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_value = vals[i+1];
      assign right_valid = valids[i+1];
    end

    bsle_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_value  (new_value),
      .head_value (vals[0]),
      .left_value (left_value),
      .left_valid (left_valid),
      .right_value(right_value),
      .right_valid(right_valid),
      .hit_in     (hits[i]),
      .hit_out    (hits[i+1]),
      .value      (vals[i]),
      .valid      (valids[i])
    );
  end

endmodule

[src/bounded_sorted_list_engine_unit.sv]
// An insert transaction's result is registered for the next cycle.
// Inserts therefore sustain one transaction per cycle while the output is not stalled.
// A read out emits one entry per cycle from the head of the cell chain, which rotates as it
// goes, while the output is not stalled; no new transaction is taken until the last entry is
// registered, and a read out of an empty list is timed like an insert.
// Reset clears the entry count, the cell valid bits and the output; stored values are undefined.
`include "bounded_sorted_list_engine_unit_assert.svh"

module bounded_sorted_list_engine_unit #(
  parameter int CAPACITY    = bsle_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bsle_pkg::VALUE_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bsle_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bsle_pkg::out_t out_data
);
  import bsle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                     state_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              idx_r;
  logic                       out_valid_r;
  out_t                       out_data_r;

  logic                       out_free;
  logic                       in_acc;
  logic                       full;
  logic                       is_read;
  logic                       read_last;
  cell_ctrl_t                 ctrl;
  logic [VALUE_WIDTH-1:0]     new_value;
  logic [VALUE_WIDTH-1:0]     head_value;
  logic [VALUE_WIDTH+FIELD_W-1:0] in_ext;
  logic [FIELD_W+VALUE_WIDTH-1:0] head_ext;
  logic [CW+OCC_W-1:0]        count_ext;
  logic [CW+OCC_W-1:0]        count_inc_ext;
  logic [CW-1:0]              count_inc;
  logic [OCC_W-1:0]           occ;
  logic [OCC_W-1:0]           occ_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == CW'(CAPACITY));
  assign is_read   = (in_data.kind == KIND_READ);
  assign read_last = (idx_r == count_r - CW'(1));

  assign in_ext    = {{VALUE_WIDTH{1'b0}}, in_data.value};
  assign new_value = in_ext[VALUE_WIDTH-1:0];
  assign head_ext  = {{FIELD_W{1'b0}}, head_value};

  assign count_inc     = count_r + CW'(1);
  assign count_ext     = {{OCC_W{1'b0}}, count_r};
  assign count_inc_ext = {{OCC_W{1'b0}}, count_inc};
  assign occ           = count_ext[OCC_W-1:0];
  assign occ_inc       = count_inc_ext[OCC_W-1:0];

  always_comb begin
    ctrl.ins  = in_acc && !is_read && !full;
    ctrl.rot  = (state_r == ST_READ) && out_free;
    ctrl.kind = in_data.kind;
  end

  bsle_chain #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .new_value (new_value),
    .head_value(head_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            out_data_r.item_value <= '0;
            out_data_r.last       <= 1'b1;
            if (is_read) begin
              if (count_r == '0) begin
                out_valid_r          <= 1'b1;
                out_data_r.occupancy <= '0;
                out_data_r.status    <= STATUS_EMPTY;
              end else begin
                out_valid_r <= 1'b0;
                idx_r       <= '0;
                state_r     <= ST_READ;
              end
            end else if (full) begin
              out_valid_r          <= 1'b1;
              out_data_r.occupancy <= occ;
              out_data_r.status    <= STATUS_FULL;
            end else begin
              out_valid_r          <= 1'b1;
              out_data_r.occupancy <= occ_inc;
              out_data_r.status    <= STATUS_DONE;
              count_r              <= count_inc;
            end
          end else if (out_free) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_data_r.item_value <= head_ext[FIELD_W-1:0];
            out_data_r.occupancy  <= occ;
            out_data_r.status     <= STATUS_DONE;
            out_data_r.last       <= read_last;
            idx_r                 <= idx_r + CW'(1);
            if (read_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BSLE_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `BSLE_ASSERT_NEXT(a_insert_count, clk, rst_n, ctrl.ins, count_r == $past(count_inc))
  `BSLE_ASSERT_NEXT(a_read_count, clk, rst_n, state_r == ST_READ, $stable(count_r))

endmodule

[bench/bounded_sorted_list_engine_unit_test.sv]
module bounded_sorted_list_engine_unit_test;
  import bsle_pkg::*;

  localparam int LIST_CAPACITY = CAPACITY_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 215;
  localparam int QUIET_ITEMS   = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic signed [31:0] list_entries[$];
  out_t               list_responses[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  full_drops = 0;
  int  readouts = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet_tail = 1'b0;

  bounded_sorted_list_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void apply_list_op(in_t op);
    out_t               resp;
    logic signed [31:0] v;
    int                 pos;
    v = op.value;
    resp.item_value = '0;
    resp.occupancy  = '0;
    resp.status     = STATUS_DONE;
    resp.last       = 1'b1;
    if (op.kind == KIND_READ) begin
      readouts++;
      if (list_entries.size() == 0) begin
        resp.status = STATUS_EMPTY;
        list_responses.push_back(resp);
      end else begin
        foreach (list_entries[i]) begin
          resp.item_value = list_entries[i];
          resp.occupancy  = OCC_W'(list_entries.size());
          resp.last       = (i == list_entries.size() - 1);
          list_responses.push_back(resp);
        end
      end
    end else if (list_entries.size() >= LIST_CAPACITY) begin
      full_drops++;
      resp.status    = STATUS_FULL;
      resp.occupancy = OCC_W'(LIST_CAPACITY);
      list_responses.push_back(resp);
    end else begin
      case (op.kind)
        KIND_FRONT: begin
          list_entries.push_front(v);
        end
        KIND_BACK: begin
          list_entries.push_back(v);
        end
        default: begin
          pos = 0;
          while (pos < list_entries.size() && list_entries[pos] < v) pos++;
          list_entries.insert(pos, v);
        end
      endcase
      resp.occupancy = OCC_W'(list_entries.size());
      list_responses.push_back(resp);
    end
  endfunction

  task automatic push_list_op(input kind_t kind, input logic signed [31:0] value);
    in_t op;
    op.kind  = kind;
    op.value = value;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_op(op);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (list_responses.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(0, 6) - 3;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n || quiet_tail) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (list_responses.size() == 0) begin
        report_mismatch("result with nothing pending", out_data.item_value, 32'd0);
      end else begin
        want = list_responses.pop_front();
        if (out_data.item_value !== want.item_value)
          report_mismatch("item_value", out_data.item_value, want.item_value);
        if (out_data.occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(out_data.occupancy), 32'(want.occupancy));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.last !== want.last)
          report_mismatch("last", 32'(out_data.last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic test_empty_readout();
    push_list_op(KIND_READ, 32'sh0);
    push_list_op(KIND_READ, 32'shffffffff);
  endtask

  task automatic test_sorted_edges();
    push_list_op(KIND_SORTED, 32'sh0);
    push_list_op(KIND_SORTED, 32'sh0);
    push_list_op(KIND_SORTED, -32'sh1);
    push_list_op(KIND_SORTED, 32'sh80000000);
    push_list_op(KIND_SORTED, 32'sh7fffffff);
    push_list_op(KIND_SORTED, 32'sh5);
    push_list_op(KIND_SORTED, 32'sh7fffffff);
    push_list_op(KIND_SORTED, -32'sh1);
    push_list_op(KIND_FRONT, 32'sh7fffffff);
    push_list_op(KIND_BACK, 32'sh80000000);
    push_list_op(KIND_READ, 32'sh0);
  endtask

  task automatic test_fill_to_capacity();
    while (list_entries.size() < LIST_CAPACITY) begin
      if ($urandom_range(0, 4) == 0)
        push_list_op(KIND_READ, $urandom);
      else
        push_list_op(kind_t'($urandom_range(0, 2)), pick_value());
    end
  endtask

  task automatic test_full_list();
    push_list_op(KIND_FRONT, 32'sh7fffffff);
    push_list_op(KIND_BACK, 32'sh80000000);
    push_list_op(KIND_SORTED, 32'sh0);
    push_list_op(KIND_READ, 32'sh0);
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      push_list_op(kind_t'($urandom_range(0, 3)), pick_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_readout();
    test_sorted_edges();
    wait_drained();
    test_fill_to_capacity();
    test_full_list();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (list_responses.size() != 0)
      report_mismatch("results never delivered", 32'(list_responses.size()), 32'd0);
    $display("Sent %0d transactions (%0d read outs, %0d dropped as full); checked %0d results.",
             items_sent, readouts, full_drops, results_seen);
    $display("Covered front, back and sorted inserts with extreme and equal values.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
